// ===== rtl/core/dual_key_debounce_hold_adjust_unit_macros.svh =====
// Assertion macros used by the checker of the key debounce unit
`ifndef DUAL_KEY_DEBOUNCE_HOLD_ADJUST_UNIT_MACROS_SVH
`define DUAL_KEY_DEBOUNCE_HOLD_ADJUST_UNIT_MACROS_SVH

// Same-cycle implication, muted while reset is high
`define DKDHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted while reset is high
`define DKDHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dkdha_pkg.sv =====
package dkdha_pkg;

  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned TICK_W       = 32;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [PERIOD_W-1:0] PERIOD_START_DEF = 16'd500;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST   = 16'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST   = 16'd1900;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_MIN = 1'b0,
    REG_PERIOD_MAX = 1'b1
  } cfg_reg_t;

  // Input word: one sampling tick
  typedef struct packed {
    logic              key_up_level;
    logic              key_down_level;
    logic [TICK_W-1:0] now_ticks;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [PERIOD_W-1:0] period_value;
    logic                up_released;
    logic [TICK_W-1:0]   up_hold_time;
    logic                down_released;
    logic [TICK_W-1:0]   down_hold_time;
  } out_word_t;

  // Release report from one debouncer
  typedef struct packed {
    logic              released;
    logic [TICK_W-1:0] hold;
  } rel_t;

endpackage

// ===== rtl/core/dkdha_debounce.sv =====
module dkdha_debounce
  import dkdha_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              level,
  input  logic [TICK_W-1:0] now_ticks,
  output rel_t              rel
);

  typedef enum logic [1:0] {
    PH_UP      = 2'd0,
    PH_FALLING = 2'd1,
    PH_DOWN    = 2'd2,
    PH_RISING  = 2'd3
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  logic [TICK_W-1:0] stamp;
  logic              pressed;
  logic              take_stamp;

  assign pressed = ~level;

  // Advance the debouncer; two equal samples confirm a change
  always_comb begin
    phase_next   = phase;
    take_stamp   = 1'b0;
    rel.released = 1'b0;
    unique case (phase)
      PH_UP: begin
        if (pressed) phase_next = PH_FALLING;
      end
      PH_FALLING: begin
        if (pressed) begin
          phase_next = PH_DOWN;
          take_stamp = 1'b1;
        end else begin
          phase_next = PH_UP;
        end
      end
      PH_DOWN: begin
        if (!pressed) phase_next = PH_RISING;
      end
      PH_RISING: begin
        if (!pressed) begin
          phase_next   = PH_UP;
          rel.released = 1'b1;
        end else begin
          phase_next = PH_DOWN;
        end
      end
      default: phase_next = PH_UP;
    endcase
    // Hold time wraps at 32 bits; zero when no release
    rel.hold = rel.released ? (now_ticks - stamp) : '0;
  end

  // Hold phase and press stamp
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_UP;
      stamp <= '0;
    end else if (step) begin
      phase <= phase_next;
      if (take_stamp) stamp <= now_ticks;
    end
  end

endmodule

// ===== rtl/core/dkdha_period.sv =====
module dkdha_period
  import dkdha_pkg::*;
#(
  parameter logic [PERIOD_W-1:0] PERIOD_START = PERIOD_START_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  rel_t                 up_rel,
  input  rel_t                 down_rel,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_data,
  output logic [PERIOD_W-1:0]  period_next
);

  localparam int unsigned WIDE_W = TICK_W + 1;

  logic [PERIOD_W-1:0] period_reg;
  logic [PERIOD_W-1:0] period_min;
  logic [PERIOD_W-1:0] period_max;
  logic [PERIOD_W-1:0] period_mid;
  logic [WIDE_W-1:0]   up_sum;
  logic [WIDE_W-1:0]   down_bound;

  // Increase first, saturating at the ceiling
  assign up_sum = WIDE_W'(period_reg) + WIDE_W'(up_rel.hold);

  always_comb begin
    period_mid = period_reg;
    if (up_rel.released) begin
      if (up_sum > WIDE_W'(period_max)) period_mid = period_max;
      else                              period_mid = up_sum[PERIOD_W-1:0];
    end
  end

  // Then decrease, flooring at the lower limit
  assign down_bound = WIDE_W'(period_min) + WIDE_W'(down_rel.hold);

  always_comb begin
    period_next = period_mid;
    if (down_rel.released) begin
      if (WIDE_W'(period_mid) < down_bound) period_next = period_min;
      else period_next = period_mid - down_rel.hold[PERIOD_W-1:0];
    end
  end

  // Hold period and limits
  always_ff @(posedge clk) begin
    if (rst) begin
      period_reg <= PERIOD_START;
      period_min <= PERIOD_MIN_RST;
      period_max <= PERIOD_MAX_RST;
    end else begin
      if (step) period_reg <= period_next;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PERIOD_MIN: period_min <= cfg_data;
          REG_PERIOD_MAX: period_max <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/dual_key_debounce_hold_adjust_unit.sv =====
// Throughput: one word per cycle while the result register is not stalled;
//   input register, then single-pass logic into the result register, with
//   state updated as the result is written.
// Reset (rst, synchronous): both keys up, press stamps zero, period at
//   PERIOD_START, limits at 100 and 1900; no clearing pass.
module dual_key_debounce_hold_adjust_unit
  import dkdha_pkg::*;
#(
  parameter logic [PERIOD_W-1:0] PERIOD_START = PERIOD_START_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_data
);

  logic                in_vld;
  in_word_t            in_reg;
  logic                advance;
  logic                step;
  rel_t                up_rel;
  rel_t                down_rel;
  logic [PERIOD_W-1:0] period_next;

  // Move the input stage when the result register is free or draining
  assign advance   = !out_valid || !out_stall;
  assign step      = in_vld && advance;
  assign in_stall  = in_vld && !advance;
  assign cfg_ready = 1'b1;

  dkdha_debounce u_up (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .level     (in_reg.key_up_level),
    .now_ticks (in_reg.now_ticks),
    .rel       (up_rel)
  );

  dkdha_debounce u_down (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .level     (in_reg.key_down_level),
    .now_ticks (in_reg.now_ticks),
    .rel       (down_rel)
  );

  dkdha_period #(
    .PERIOD_START (PERIOD_START)
  ) u_period (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .up_rel      (up_rel),
    .down_rel    (down_rel),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .period_next (period_next)
  );

  // Input stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_reg <= in_data;
  end

  // Result stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_vld;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (step) begin
      out_data.period_value   <= period_next;
      out_data.up_released    <= up_rel.released;
      out_data.up_hold_time   <= up_rel.hold;
      out_data.down_released  <= down_rel.released;
      out_data.down_hold_time <= down_rel.hold;
    end
  end

endmodule

// ===== rtl/core/dkdha_checker.sv =====
`include "dual_key_debounce_hold_adjust_unit_macros.svh"

module dkdha_checker
  import dkdha_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // A stalled result word holds
  `DKDHA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result word changed while stalled")

  // Hold times are zero without a release
  `DKDHA_ASSERT_NOW(a_up_zero, clk, rst, out_valid && !out_data.up_released, out_data.up_hold_time == '0, "up hold time without release")
  `DKDHA_ASSERT_NOW(a_down_zero, clk, rst, out_valid && !out_data.down_released, out_data.down_hold_time == '0, "down hold time without release")

  // An empty result register never stalls the input
  `DKDHA_ASSERT_NOW(a_no_stall, clk, rst, !out_valid, !in_stall, "input stalled with empty result register")

endmodule

bind dual_key_debounce_hold_adjust_unit dkdha_checker u_dkdha_checker (.*);
